/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the encoder qualifier RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held
`define ASSERT_CLK(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed: %m");

// Clocked check that also holds during reset
`define ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: %m");

`endif

/* sv/rebq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebq_pkg
// Types, codes and the quadrature step table for the encoder qualifier.
// ----------------------------------------------------------------------------
package rebq_pkg;

    // Default width of the tick counters
    localparam int TICK_COUNTER_WIDTH_DEFAULT = 16;

    // Field widths
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int THR_W       = 3;
    localparam int ACC_W       = 4;

    // Register reset values
    localparam logic [15:0]      DEBOUNCE_RESET   = 16'd50;
    localparam logic [15:0]      LONG_PRESS_RESET = 16'd1000;
    localparam logic [THR_W-1:0] DETENT_RESET     = 3'd2;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DETENT     = 2'd2;

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_CW   = 2'd1,
        ROT_CCW  = 2'd2
    } t_rotation;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_LONG  = 2'd1,
        EV_CLICK = 2'd2
    } t_button_event;

    // Button timing settings handed to the button qualifier
    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [15:0] long_press_ticks;
    } t_btn_cfg;

    // Quadrature step from old and new AB pair (A is the high bit)
    function automatic logic signed [ACC_W:0] quad_step(input logic [1:0] prev_ab,
                                                       input logic [1:0] cur_ab);
        logic signed [ACC_W:0] step;
        step = '0;
        case ({prev_ab, cur_ab})
            4'b0001, 4'b0111, 4'b1000, 4'b1110: step = 5'sd1;
            4'b0010, 4'b0100, 4'b1011, 4'b1101: step = -5'sd1;
            default:                            step = '0;
        endcase
        return step;
    endfunction

endpackage

/* sv/rebq_button.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rebq_button
// Push button debounce, hold timing and click / long press event decode.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rebq_button #(
    parameter int TICK_COUNTER_WIDTH = rebq_pkg::TICK_COUNTER_WIDTH_DEFAULT
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic                     i_button_level,
    input  rebq_pkg::t_btn_cfg       i_cfg,
    output rebq_pkg::t_button_event  o_event
);

    localparam int CMP_W = (TICK_COUNTER_WIDTH > 16) ? TICK_COUNTER_WIDTH : 16;

    logic                          r_raw, n_raw;
    logic                          r_stable, n_stable;
    logic [TICK_COUNTER_WIDTH-1:0] r_dcount, n_dcount;
    logic [TICK_COUNTER_WIDTH-1:0] r_hold, n_hold;
    logic                          r_pressed, n_pressed;
    logic                          r_long, n_long;
    rebq_pkg::t_button_event       n_event;
    logic [CMP_W-1:0]              dcount_ext;
    logic [CMP_W-1:0]              hold_ext;

    // Work out the tick's button state and event
    always_comb begin
        n_raw     = r_raw;
        n_stable  = r_stable;
        n_pressed = r_pressed;
        n_long    = r_long;
        n_event   = rebq_pkg::EV_NONE;

        // restart the debounce count on a raw change, else saturate upwards
        if (i_button_level != r_raw) begin
            n_raw    = i_button_level;
            n_dcount = '0;
        end else begin
            n_dcount = (&r_dcount) ? r_dcount : r_dcount + 1'b1;
        end

        if (r_pressed) begin
            n_hold = (&r_hold) ? r_hold : r_hold + 1'b1;
        end else begin
            n_hold = r_hold;
        end

        dcount_ext = CMP_W'(n_dcount);

        // stable level follows once the raw level has settled
        if ((dcount_ext > CMP_W'(i_cfg.debounce_ticks)) && (i_button_level != r_stable)) begin
            n_stable = i_button_level;
            if (!i_button_level) begin
                n_pressed = 1'b1;
                n_hold    = '0;
                n_long    = 1'b0;
            end else begin
                n_pressed = 1'b0;
                n_event   = rebq_pkg::EV_CLICK;
            end
        end

        hold_ext = CMP_W'(n_hold);

        // long press fires once per press
        if (n_pressed && !n_long && (hold_ext > CMP_W'(i_cfg.long_press_ticks))) begin
            n_long  = 1'b1;
            n_event = rebq_pkg::EV_LONG;
        end
    end

    // Advance button state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw     <= 1'b1;
            r_stable  <= 1'b1;
            r_dcount  <= '0;
            r_hold    <= '0;
            r_pressed <= 1'b0;
            r_long    <= 1'b0;
        end else if (i_accept) begin
            r_raw     <= n_raw;
            r_stable  <= n_stable;
            r_dcount  <= n_dcount;
            r_hold    <= n_hold;
            r_pressed <= n_pressed;
            r_long    <= n_long;
        end
    end

    assign o_event = n_event;

    `ASSERT_CLK(a_long_needs_fresh_press, i_clk, i_rst_n, (n_event == rebq_pkg::EV_LONG) |-> (n_pressed && !r_long))
    `ASSERT_CLK(a_click_ends_press, i_clk, i_rst_n, (i_accept && (n_event == rebq_pkg::EV_CLICK)) |=> !r_pressed)

endmodule

/* sv/rotary_encoder_button_qualifier.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_encoder_button_qualifier
// Quadrature decode with detent counting and push button debounce per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one beat per millisecond
//   tick: sampled encoder levels A and B and the raw button level.
//   Output channel (o_out_valid / i_out_stall) returns exactly one beat per
//   input beat: the rotation detent code and the button event code.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes debounce ticks,
//   long press ticks and detent threshold; write only while the block is idle.
//   The decoded result is registered in the output register; one beat is taken
//   in every cycle while o_in_stall is low. A single pass of decode logic lies
//   between the state registers and the output register.
//   When the receiver stalls, the result waits in the output register and one
//   more beat is taken into a skid register; o_in_stall then rises until the
//   output drains.
//   Synchronous active-low reset clears the encoder and button state, empties
//   the output path and restores the register defaults.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotary_encoder_button_qualifier #(
    parameter int TICK_COUNTER_WIDTH = rebq_pkg::TICK_COUNTER_WIDTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input beat
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_phase_a,
    input  logic                             i_phase_b,
    input  logic                             i_button_level,
    // output beat
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [1:0]                       o_rotation,
    output logic [1:0]                       o_button_event,
    // configuration writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rebq_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [rebq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int ACC_W = rebq_pkg::ACC_W;

    logic [15:0]                 r_debounce_ticks;
    logic [15:0]                 r_long_press_ticks;
    logic [rebq_pkg::THR_W-1:0]  r_detent;

    logic                        r_prev_a, r_prev_b;
    logic signed [ACC_W-1:0]     r_acc, n_acc;

    logic                        in_accept;
    logic                        out_take;
    rebq_pkg::t_rotation         n_rotation;
    rebq_pkg::t_button_event     btn_event;
    rebq_pkg::t_btn_cfg          btn_cfg;

    logic signed [ACC_W:0]       sum;
    logic signed [ACC_W:0]       sat;
    logic signed [ACC_W:0]       thr;

    logic                        r_out_valid;
    rebq_pkg::t_rotation         r_out_rot;
    rebq_pkg::t_button_event     r_out_ev;
    logic                        r_skid_valid;
    rebq_pkg::t_rotation         r_skid_rot;
    rebq_pkg::t_button_event     r_skid_ev;

    assign in_accept  = i_in_valid && !r_skid_valid;
    assign out_take   = r_out_valid && !i_out_stall;
    assign o_in_stall = r_skid_valid;
    assign o_cfg_ready = 1'b1;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks   <= rebq_pkg::DEBOUNCE_RESET;
            r_long_press_ticks <= rebq_pkg::LONG_PRESS_RESET;
            r_detent           <= rebq_pkg::DETENT_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rebq_pkg::CFG_DEBOUNCE:   r_debounce_ticks   <= i_cfg_data;
                rebq_pkg::CFG_LONG_PRESS: r_long_press_ticks <= i_cfg_data;
                rebq_pkg::CFG_DETENT:     r_detent           <= i_cfg_data[rebq_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Decode quadrature step, saturate, then strip whole detents
    always_comb begin
        sum = {r_acc[ACC_W-1], r_acc} + rebq_pkg::quad_step({r_prev_a, r_prev_b},
                                                            {i_phase_a, i_phase_b});
        if (sum > 5'sd7) begin
            sat = 5'sd7;
        end else if (sum < -5'sd8) begin
            sat = -5'sd8;
        end else begin
            sat = sum;
        end

        // zero threshold acts as one
        thr = (r_detent == '0) ? 5'sd1 : $signed({2'b00, r_detent});

        n_rotation = rebq_pkg::ROT_NONE;
        n_acc      = sat[ACC_W-1:0];
        if (sat >= thr) begin
            n_rotation = rebq_pkg::ROT_CW;
            n_acc      = ACC_W'(sat - thr);
        end else if (sat <= -thr) begin
            n_rotation = rebq_pkg::ROT_CCW;
            n_acc      = ACC_W'(sat + thr);
        end
    end

    // Advance encoder state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a <= 1'b1;
            r_prev_b <= 1'b1;
            r_acc    <= '0;
        end else if (in_accept) begin
            r_prev_a <= i_phase_a;
            r_prev_b <= i_phase_b;
            r_acc    <= n_acc;
        end
    end

    assign btn_cfg.debounce_ticks   = r_debounce_ticks;
    assign btn_cfg.long_press_ticks = r_long_press_ticks;

    rebq_button #(
        .TICK_COUNTER_WIDTH(TICK_COUNTER_WIDTH)
    ) u_button (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_button_level (i_button_level),
        .i_cfg          (btn_cfg),
        .o_event        (btn_event)
    );

    // Output register and skid stage: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            r_out_valid  <= r_skid_valid || in_accept;
            r_skid_valid <= 1'b0;
        end else if (in_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    // Output register and skid stage: payload
    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            if (r_skid_valid) begin
                r_out_rot <= r_skid_rot;
                r_out_ev  <= r_skid_ev;
            end else if (in_accept) begin
                r_out_rot <= n_rotation;
                r_out_ev  <= btn_event;
            end
        end else if (in_accept) begin
            r_skid_rot <= n_rotation;
            r_skid_ev  <= btn_event;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_rotation     = r_out_rot;
    assign o_button_event = r_out_ev;

    `ASSERT_ALWAYS(a_skid_behind_output, i_clk, r_skid_valid |-> r_out_valid)
    `ASSERT_CLK(a_stall_fills_skid, i_clk, i_rst_n, (r_out_valid && i_out_stall && in_accept) |=> r_skid_valid)

endmodule
